[rtl/hsl_pkg.sv]
// Package for the HSL/HSV to RGB converter: payload structs, sector codes and
// fixed-point constants for the chroma datapath and the rounding lanes.
// No dependencies.
package hsl_pkg;

  // Input request and result payloads
  typedef struct packed {
    logic [8:0] hue;
    logic [6:0] saturation;
    logic [6:0] level;
  } in_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } out_t;

  // 60-degree hue sectors, named by the colors at their ends
  typedef enum logic [2:0] {
    SEC_RED_YEL,
    SEC_YEL_GRN,
    SEC_GRN_CYA,
    SEC_CYA_BLU,
    SEC_BLU_MAG,
    SEC_MAG_RED
  } sector_t;

  // Channel numerators over 600000 (full scale fits in 20 bits)
  localparam int NUM_W = 20;

  typedef struct packed {
    logic [NUM_W-1:0] red_num;
    logic [NUM_W-1:0] green_num;
    logic [NUM_W-1:0] blue_num;
  } chan_num_t;

  localparam logic [8:0] HUE_WRAP = 9'd360;
  localparam logic [6:0] PCT_MAX  = 7'd100;

  // 255*n/600000 rounded half up == floor((17*n + 20000) / 40000)
  // 40000 = 64 * 625; the /625 is a reciprocal multiply, exact for y < 2^18
  localparam int              ROUND_W     = 24;
  localparam int              QUO_W       = 18;
  localparam int              RECIP_W     = 19;
  localparam int              PROD_W      = QUO_W + RECIP_W;
  localparam int              RECIP_SHIFT = 28;
  localparam logic [4:0]      SCALE_MUL   = 5'd17;
  localparam logic [14:0]     ROUND_BIAS  = 15'd20000;
  localparam logic [18:0]     RECIP_M     = 19'd429497;

endpackage

[rtl/hsl_hsv_to_rgb_converter.sv]
// HSL/HSV to RGB converter: one request per cycle while the output is not
// stalled, sustained by the fully pipelined datapath (4 chroma stages,
// 2 rounding stages, output register).
// A stalled output freezes the whole pipeline. Synchronous active-low reset
// clears all valid bits and sets source_space to HSV.
// Top level; depends on hsl_pkg, hsl_chroma, hsl_round.
module hsl_hsv_to_rgb_converter import hsl_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic cfg_data
);

  // Mode register
  logic source_space_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      source_space_r <= 1'b0;
    end else if (cfg_valid) begin
      source_space_r <= cfg_data;
    end
  end

  // Global advance: move when the output slot is free or being taken
  logic out_valid_r;
  logic adv;

  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  // Chroma stages
  logic      n_valid;
  chan_num_t n_data;

  hsl_chroma u_chroma (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .hsl_mode (source_space_r),
    .in_valid (in_valid),
    .in_data  (in_data),
    .n_valid  (n_valid),
    .n_data   (n_data)
  );

  // Rounding lanes
  logic [7:0] red_c, green_c, blue_c;

  hsl_round u_round_r (.clk(clk), .adv(adv), .num(n_data.red_num),   .chan(red_c));
  hsl_round u_round_g (.clk(clk), .adv(adv), .num(n_data.green_num), .chan(green_c));
  hsl_round u_round_b (.clk(clk), .adv(adv), .num(n_data.blue_num),  .chan(blue_c));

  // Valid bits alongside the rounding stages
  logic v5_r, v6_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r        <= 1'b0;
      v6_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v5_r        <= n_valid;
      v6_r        <= v5_r;
      out_valid_r <= v6_r;
    end
  end

  // Output register
  out_t out_data_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r.red   <= red_c;
      out_data_r.green <= green_c;
      out_data_r.blue  <= blue_c;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Checks
  a_stall_holds_valids: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable({n_valid, v5_r, v6_r}))
    else $error("pipeline valid bits moved during a stall");

  a_out_from_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(v6_r))
    else $error("result appeared without a request in the last stage");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !in_ready)
    else $error("input taken while output stalled");

endmodule

[rtl/hsl_chroma.sv]
// Four-stage chroma datapath: hue sector and ramp, chroma product, component
// terms and offset, per-channel numerators. Depends on hsl_pkg.
module hsl_chroma import hsl_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      adv,
  input  logic      hsl_mode,
  input  logic      in_valid,
  input  in_t       in_data,
  output logic      n_valid,
  output chan_num_t n_data
);

  // Stage 1: clamp, wrap hue, find sector and ramp position
  logic [6:0]  s_sat, l_sat, a_val, r_pos;
  logic [8:0]  h_red, h_base;
  logic [5:0]  k_val;
  sector_t     sec;

  always_comb begin
    s_sat = (in_data.saturation > PCT_MAX) ? PCT_MAX : in_data.saturation;
    l_sat = (in_data.level > PCT_MAX) ? PCT_MAX : in_data.level;
    h_red = (in_data.hue >= HUE_WRAP) ? 9'(in_data.hue - HUE_WRAP) : in_data.hue;
    if (h_red < 9'd60) begin
      sec = SEC_RED_YEL;
    end else if (h_red < 9'd120) begin
      sec = SEC_YEL_GRN;
    end else if (h_red < 9'd180) begin
      sec = SEC_GRN_CYA;
    end else if (h_red < 9'd240) begin
      sec = SEC_CYA_BLU;
    end else if (h_red < 9'd300) begin
      sec = SEC_BLU_MAG;
    end else begin
      sec = SEC_MAG_RED;
    end
    case (sec)
      SEC_RED_YEL, SEC_YEL_GRN: h_base = 9'd0;
      SEC_GRN_CYA, SEC_CYA_BLU: h_base = 9'd120;
      default:                  h_base = 9'd240;
    endcase
    r_pos = 7'(h_red - h_base);
    k_val = (r_pos < 7'd60) ? r_pos[5:0] : 6'(7'd120 - r_pos);
    // HSL lightness weight 100 - |2L - 100|
    a_val = (l_sat <= 7'd50) ? 7'({1'b0, l_sat} << 1)
                             : 7'(8'd200 - {l_sat, 1'b0});
  end

  logic        v1_r;
  sector_t     sec1_r;
  logic [5:0]  k1_r;
  logic [6:0]  base1_r, s1_r, l1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sec1_r  <= sec;
      k1_r    <= k_val;
      base1_r <= hsl_mode ? a_val : l_sat;
      s1_r    <= s_sat;
      l1_r    <= l_sat;
    end
  end

  // Stage 2: chroma product (percent squared)
  logic        v2_r;
  sector_t     sec2_r;
  logic [5:0]  k2_r;
  logic [6:0]  l2_r;
  logic [13:0] p2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sec2_r <= sec1_r;
      k2_r   <= k1_r;
      l2_r   <= l1_r;
      p2_r   <= 14'(base1_r * s1_r);
    end
  end

  // Stage 3: chroma and secondary terms, offset before scaling
  logic [14:0] l200, p_sub, q_val;

  always_comb begin
    l200  = 15'(l2_r * 8'd200);
    p_sub = hsl_mode ? {1'b0, p2_r} : {p2_r, 1'b0};
    q_val = 15'(l200 - p_sub);
  end

  logic             v3_r;
  sector_t          sec3_r;
  logic [NUM_W-1:0] c3_r, x3_r;
  logic [14:0]      q3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (adv) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sec3_r <= sec2_r;
      c3_r   <= NUM_W'(p2_r * 6'd60);
      x3_r   <= NUM_W'(p2_r * k2_r);
      q3_r   <= q_val;
    end
  end

  // Stage 4: channel order by sector, add offset
  logic [NUM_W-1:0] m_val, rc, gc, bc;

  always_comb begin
    m_val = NUM_W'(q3_r * 5'd30);
    case (sec3_r)
      SEC_RED_YEL: begin rc = c3_r;  gc = x3_r;  bc = '0;    end
      SEC_YEL_GRN: begin rc = x3_r;  gc = c3_r;  bc = '0;    end
      SEC_GRN_CYA: begin rc = '0;    gc = c3_r;  bc = x3_r;  end
      SEC_CYA_BLU: begin rc = '0;    gc = x3_r;  bc = c3_r;  end
      SEC_BLU_MAG: begin rc = x3_r;  gc = '0;    bc = c3_r;  end
      default:     begin rc = c3_r;  gc = '0;    bc = x3_r;  end
    endcase
  end

  logic      v4_r;
  chan_num_t n4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (adv) begin
      v4_r <= v3_r;
    end
  end

  // sums never exceed full scale 600000
  always_ff @(posedge clk) begin
    if (adv) begin
      n4_r.red_num   <= NUM_W'(rc + m_val);
      n4_r.green_num <= NUM_W'(gc + m_val);
      n4_r.blue_num  <= NUM_W'(bc + m_val);
    end
  end

  assign n_valid = v4_r;
  assign n_data  = n4_r;

endmodule

[rtl/hsl_round.sv]
// One rounding lane: scales a numerator over 600000 to 0..255, half up,
// in two register stages. Depends on hsl_pkg.
module hsl_round import hsl_pkg::*; (
  input  logic             clk,
  input  logic             adv,
  input  logic [NUM_W-1:0] num,
  output logic [7:0]       chan
);

  // Stage A: 17*n + 20000, drop the factor of 64
  logic [ROUND_W-1:0] biased;
  logic [QUO_W-1:0]   y_r;

  assign biased = ROUND_W'(num * SCALE_MUL) + ROUND_W'(ROUND_BIAS);

  always_ff @(posedge clk) begin
    if (adv) begin
      y_r <= biased[ROUND_W-1:6];
    end
  end

  // Stage B: divide by 625 via reciprocal multiply
  logic [PROD_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      prod_r <= PROD_W'(y_r * RECIP_M);
    end
  end

  // quotient and clamp
  logic [PROD_W-RECIP_SHIFT-1:0] quo;

  assign quo  = prod_r[PROD_W-1:RECIP_SHIFT];
  assign chan = (quo > 255) ? 8'd255 : quo[7:0];

endmodule

[tb/testbench.sv]
// Self-checking testbench for the HSL/HSV to RGB converter: directed table,
// then random bursts under backpressure, checked by a local model or table.
// Depends on hsl_pkg and hsl_hsv_to_rgb_converter.
`timescale 1ns / 1ps

module testbench;
  import hsl_pkg::*;

  localparam longint CHAN_DENOM = 6000000;
  localparam int RAND_PHASES = 5;
  localparam int PHASE_ITEMS = 105;
  localparam int TAIL_CYCLES = 10;

  typedef enum int {STALL_NONE, STALL_RANDOM, STALL_PERIODIC, STALL_LONG} stall_style_t;

  // One directed row: color space, request, and an optional typed-in result
  typedef struct {
    logic hsl;
    in_t  px;
    bit   typed;
    out_t rgb;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_data = 1'b0;

  // Travels with the request: use the typed-in result instead of the model
  bit   use_typed = 1'b0;
  out_t typed_rgb = '0;

  logic     hsl_mode = 1'b0;
  out_t     rgb_expected[$];
  dir_row_t directed_rows[$];
  int       mismatch_count = 0;
  int       pixels_sent = 0;
  int       hsl_pixels = 0;
  int       clamped_pixels = 0;
  int       results_checked = 0;
  int       space_writes = 0;

  int hue_corners[15] = '{0, 1, 59, 60, 61, 119, 120, 179, 180, 239, 240, 299, 300, 359, 360};
  int pct_corners[7]  = '{0, 1, 49, 50, 51, 99, 100};

  hsl_hsv_to_rgb_converter DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  // Scale a numerator over CHAN_DENOM to 0..255, half up
  function automatic logic [7:0] round_chan(longint num);
    longint v;
    if (num < 0) num = 0;
    v = (510 * num + CHAN_DENOM) / (2 * CHAN_DENOM);
    if (v > 255) v = 255;
    return v[7:0];
  endfunction

  // Exact integer HSV/HSL to RGB conversion
  function automatic out_t hsx_to_rgb(in_t px, logic hsl);
    longint  h, s, l, t, k, a, cn, xn, mn, rc, gc, bc;
    sector_t sec;
    out_t    rgb;
    h = px.hue;
    s = px.saturation;
    l = px.level;
    if (s > PCT_MAX) s = PCT_MAX;
    if (l > PCT_MAX) l = PCT_MAX;
    if (h >= HUE_WRAP) h = h - HUE_WRAP;
    // distance from the nearest primary hue, 0..60
    t = (h % 120) - 60;
    k = 60 - (t < 0 ? -t : t);
    if (hsl) begin
      t = 2 * l - 100;
      a = 100 - (t < 0 ? -t : t);
      cn = a * s * 600;
      xn = a * s * k * 10;
      mn = (200 * l - a * s) * 300;
    end else begin
      cn = l * s * 600;
      xn = l * s * k * 10;
      mn = (100 * l - l * s) * 600;
    end
    sec = sector_t'(h / 60);
    case (sec)
      SEC_RED_YEL: begin rc = cn; gc = xn; bc = 0;  end
      SEC_YEL_GRN: begin rc = xn; gc = cn; bc = 0;  end
      SEC_GRN_CYA: begin rc = 0;  gc = cn; bc = xn; end
      SEC_CYA_BLU: begin rc = 0;  gc = xn; bc = cn; end
      SEC_BLU_MAG: begin rc = xn; gc = 0;  bc = cn; end
      default: begin rc = cn; gc = 0; bc = xn; end
    endcase
    rgb.red   = round_chan(rc + mn);
    rgb.green = round_chan(gc + mn);
    rgb.blue  = round_chan(bc + mn);
    return rgb;
  endfunction

  function automatic void add_row(logic hsl, int h, int s, int l,
                                  bit typed = 0, int r = 0, int g = 0, int b = 0);
    dir_row_t row;
    row.hsl = hsl;
    row.px.hue = h[8:0];
    row.px.saturation = s[6:0];
    row.px.level = l[6:0];
    row.typed = typed;
    row.rgb.red = r[7:0];
    row.rgb.green = g[7:0];
    row.rgb.blue = b[7:0];
    directed_rows.push_back(row);
  endfunction

  // Mostly nominal colors, some boundary values, some full-width garbage
  function automatic in_t random_pixel();
    in_t px;
    int  pick;
    pick = $urandom_range(0, 99);
    if (pick < 75) begin
      px.hue = 9'($urandom_range(0, 360));
      px.saturation = 7'($urandom_range(0, 100));
      px.level = 7'($urandom_range(0, 100));
    end else if (pick < 87) begin
      px.hue = 9'(hue_corners[$urandom_range(0, 14)]);
      px.saturation = 7'(pct_corners[$urandom_range(0, 6)]);
      px.level = 7'(pct_corners[$urandom_range(0, 6)]);
    end else begin
      px.hue = 9'($urandom);
      px.saturation = 7'($urandom);
      px.level = 7'($urandom);
    end
    return px;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("MISMATCH at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // Present one request from the falling edge, hold it until accepted
  task automatic send_pixel(in_t px, bit typed, out_t rgb);
    @(negedge clk);
    in_valid = 1'b1;
    in_data = px;
    use_typed = typed;
    typed_rgb = rgb;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic idle_cycles(int n);
    repeat (n) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
  endtask

  // Stop sending and wait for every outstanding result
  task automatic wait_results_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (rgb_expected.size() != 0) @(negedge clk);
  endtask

  task automatic write_space(logic hsl);
    @(negedge clk);
    in_valid = 1'b0;
    cfg_valid = 1'b1;
    cfg_data = hsl;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Receiver backpressure: the stall style changes at random
  stall_style_t stall_style = STALL_NONE;
  int style_cycles = 0;
  int ready_hold = 0;

  always @(negedge clk) begin
    if (style_cycles == 0) begin
      stall_style = stall_style_t'($urandom_range(0, 3));
      style_cycles = $urandom_range(40, 200);
    end
    style_cycles--;
    if (ready_hold > 0) begin
      ready_hold--;
    end else begin
      case (stall_style)
        STALL_NONE:     out_ready = 1'b1;
        STALL_RANDOM:   out_ready = ($urandom_range(0, 2) != 0);
        STALL_PERIODIC: begin
          out_ready = !out_ready;
          ready_hold = out_ready ? 2 : 0;
        end
        default: begin
          out_ready = !out_ready;
          ready_hold = $urandom_range(0, out_ready ? 6 : 12);
        end
      endcase
    end
  end

  // Monitor: predict on accepted requests, check accepted results in order
  always @(posedge clk) begin
    out_t want;
    if (!rst_n) begin
      hsl_mode = 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        hsl_mode = cfg_data;
        space_writes++;
      end
      if (in_valid && in_ready) begin
        rgb_expected.push_back(use_typed ? typed_rgb : hsx_to_rgb(in_data, hsl_mode));
        pixels_sent++;
        if (hsl_mode) hsl_pixels++;
        if (in_data.hue >= HUE_WRAP || in_data.saturation > PCT_MAX || in_data.level > PCT_MAX)
          clamped_pixels++;
      end
      if (out_valid && out_ready) begin
        if (rgb_expected.size() == 0) begin
          report_mismatch("unexpected result, red", out_data.red, -1);
        end else begin
          want = rgb_expected.pop_front();
          results_checked++;
          if (out_data.red !== want.red) report_mismatch("red", out_data.red, want.red);
          if (out_data.green !== want.green)
            report_mismatch("green", out_data.green, want.green);
          if (out_data.blue !== want.blue) report_mismatch("blue", out_data.blue, want.blue);
        end
      end
    end
  end

  // Stimulus
  initial begin
    logic     cur_space;
    dir_row_t row;
    int       sent;
    int       burst_len;
    int       gap;

    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    // HSV corners: black, white, primaries, hue wrap, half-grey tie, clamps
    add_row(0,   0,   0,   0, 1,   0,   0,   0);
    add_row(0,   0,   0, 100, 1, 255, 255, 255);
    add_row(0,   0, 100, 100, 1, 255,   0,   0);
    add_row(0, 120, 100, 100, 1,   0, 255,   0);
    add_row(0, 240, 100, 100, 1,   0,   0, 255);
    add_row(0, 360, 100, 100, 1, 255,   0,   0);
    add_row(0,   0,   0,  50, 1, 128, 128, 128);
    add_row(0, 120, 127, 100, 1,   0, 255,   0);
    add_row(0, 240, 100, 127, 1,   0,   0, 255);
    add_row(0,  60, 100, 100);
    add_row(0,  30,  75,  60);
    add_row(0,  90,  50,  40);
    add_row(0, 150,  33,  77);
    add_row(0, 210,  90,  10);
    add_row(0, 270,  64,  99);
    add_row(0, 330,   1,  55);
    add_row(0, 359, 100, 100);
    add_row(0, 511, 127, 127);
    // HSL corners
    add_row(1,   0, 100,  50, 1, 255,   0,   0);
    add_row(1,   0,   0, 100, 1, 255, 255, 255);
    add_row(1,   0,   0,   0, 1,   0,   0,   0);
    add_row(1,   0,   0,  50, 1, 128, 128, 128);
    add_row(1, 120, 100,  50, 1,   0, 255,   0);
    add_row(1, 240, 100,  50, 1,   0,   0, 255);
    add_row(1, 360, 100,  50, 1, 255,   0,   0);
    add_row(1, 200,  60,  30);
    add_row(1,  45,  80,  75);
    add_row(1, 300, 127, 127);

    write_space(1'b0);
    cur_space = 1'b0;
    for (int i = 0; i < directed_rows.size(); i++) begin
      row = directed_rows[i];
      if (row.hsl != cur_space) begin
        wait_results_drained();
        write_space(row.hsl);
        cur_space = row.hsl;
      end
      send_pixel(row.px, row.typed, row.rgb);
      idle_cycles($urandom_range(0, 2));
    end

    // Random phases, each under one color space, sent in bursts
    for (int phase = 0; phase < RAND_PHASES; phase++) begin
      wait_results_drained();
      cur_space = (phase < 2) ? phase[0] : logic'($urandom_range(0, 1));
      write_space(cur_space);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        burst_len = $urandom_range(1, 24);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        for (int j = 0; j < burst_len && sent < PHASE_ITEMS; j++) begin
          send_pixel(random_pixel(), 1'b0, '0);
          sent++;
        end
        idle_cycles(gap);
      end
    end

    wait_results_drained();
    repeat (TAIL_CYCLES) @(negedge clk);
    while (rgb_expected.size() != 0) begin
      void'(rgb_expected.pop_front());
      report_mismatch("missing result, count", 0, 1);
    end
    $display("Converted %0d pixels (%0d as HSL, %0d with clamped or wrapped fields),",
             pixels_sent, hsl_pixels, clamped_pixels);
    $display("checked %0d results across %0d color space writes.",
             results_checked, space_writes);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
